// ===== src/cbr_pkg.sv =====
package cbr_pkg;

   localparam int MaxWidth    = 64;
   localparam int MaxHeight   = 64;
   localparam int MaxChannels = 16;
   localparam int MaxKernel   = 7;
   localparam int MaxFilters  = 16;

   localparam int ActDepth = MaxChannels * MaxHeight * MaxWidth;
   localparam int WgtDepth = MaxFilters * MaxChannels * MaxKernel * MaxKernel;
   localparam int ActAw    = $clog2(ActDepth);
   localparam int WgtAw    = $clog2(WgtDepth);

   localparam int QueueDepth = 4;
   localparam int QueueAw    = $clog2(QueueDepth);

   typedef enum logic [1:0] {
      CMD_WRITE_ACT  = 2'd0,
      CMD_WRITE_WGT  = 2'd1,
      CMD_WRITE_BIAS = 2'd2,
      CMD_COMPUTE    = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      CSR_IN_WIDTH    = 3'd0,
      CSR_IN_HEIGHT   = 3'd1,
      CSR_IN_DEPTH    = 3'd2,
      CSR_KERNEL_SIZE = 3'd3,
      CSR_STRIDE      = 3'd4,
      CSR_OUT_WIDTH   = 3'd5,
      CSR_OUT_HEIGHT  = 3'd6,
      CSR_NUM_FILTERS = 3'd7
   } csr_index_type;

   // Classified item handed from front to back.
   typedef struct packed {
      cmd_type             cmd;
      logic                range_error;
      logic [3:0]          filter;
      logic [3:0]          channel;
      logic [5:0]          row;
      logic [5:0]          col;
      logic [2:0]          krow;
      logic [2:0]          kcol;
      logic signed [15:0]  data;
      logic signed [31:0]  bias;
      logic [5:0]          base_row;   // row * stride
      logic [5:0]          base_col;
   } work_type;

   typedef struct packed {
      logic [4:0] in_depth;
      logic [2:0] win_size;
   } cfg_type;

endpackage

// ===== src/cbr_front.sv =====
module cbr_front
   import cbr_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write,
   input  logic [2:0]         csr_index,
   input  logic [6:0]         csr_data,
   input  logic               push,
   output logic               full,
   input  logic [1:0]         req_command,
   input  logic [3:0]         req_filter_index,
   input  logic [3:0]         req_channel_index,
   input  logic [5:0]         req_row_index,
   input  logic [5:0]         req_col_index,
   input  logic [2:0]         req_kernel_row,
   input  logic [2:0]         req_kernel_col,
   input  logic signed [15:0] req_data_value,
   input  logic signed [31:0] req_bias_value,
   output cfg_type            cfg,
   output logic               work_valid,
   output work_type           work,
   input  logic               work_ready
);

   logic [6:0] plane_w_ff, plane_h_ff, out_width_ff, out_height_ff;
   logic [4:0] in_depth_ff, num_filters_ff;
   logic [2:0] win_size_ff, stride_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         plane_w_ff     <= 7'd64;
         plane_h_ff     <= 7'd64;
         in_depth_ff    <= 5'd1;
         win_size_ff    <= 3'd3;
         stride_ff      <= 3'd1;
         out_width_ff   <= 7'd62;
         out_height_ff  <= 7'd62;
         num_filters_ff <= 5'd1;
      end else if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_IN_WIDTH:    plane_w_ff     <= csr_data;
            CSR_IN_HEIGHT:   plane_h_ff     <= csr_data;
            CSR_IN_DEPTH:    in_depth_ff    <= csr_data[4:0];
            CSR_KERNEL_SIZE: win_size_ff    <= csr_data[2:0];
            CSR_STRIDE:      stride_ff      <= csr_data[2:0];
            CSR_OUT_WIDTH:   out_width_ff   <= csr_data;
            CSR_OUT_HEIGHT:  out_height_ff  <= csr_data;
            CSR_NUM_FILTERS: num_filters_ff <= csr_data[4:0];
            default: ;
         endcase
      end
   end

   assign cfg = '{in_depth: in_depth_ff, win_size: win_size_ff};

   // Classification: 6x3 products, one add and compare each.
   logic [8:0]  row_base, col_base;
   logic [9:0]  row_end, col_end;
   logic        err;
   work_type    item;

   always_comb begin
      row_base = 9'(req_row_index) * 9'(stride_ff);
      col_base = 9'(req_col_index) * 9'(stride_ff);
      row_end  = 10'(row_base) + 10'(win_size_ff);
      col_end  = 10'(col_base) + 10'(win_size_ff);
      err = 1'b0;
      if (5'(req_filter_index) >= num_filters_ff) err = 1'b1;
      if (7'(req_row_index) >= out_height_ff) err = 1'b1;
      if (7'(req_col_index) >= out_width_ff) err = 1'b1;
      if (plane_w_ff > 7'(MaxWidth) || plane_h_ff > 7'(MaxHeight)) err = 1'b1;
      if (in_depth_ff == 5'd0 || in_depth_ff > 5'(MaxChannels)) err = 1'b1;
      if (win_size_ff == 3'd0 || stride_ff == 3'd0) err = 1'b1;
      if (row_end > 10'(plane_h_ff)) err = 1'b1;
      if (col_end > 10'(plane_w_ff)) err = 1'b1;
      item.cmd         = cmd_type'(req_command);
      item.range_error = err;
      item.filter      = req_filter_index;
      item.channel     = req_channel_index;
      item.row         = req_row_index;
      item.col         = req_col_index;
      item.krow        = req_kernel_row;
      item.kcol        = req_kernel_col;
      item.data        = req_data_value;
      item.bias        = req_bias_value;
      item.base_row    = row_base[5:0];
      item.base_col    = col_base[5:0];
   end

   // Short queue between front and back.
   work_type             queue_ff [QueueDepth];
   logic [QueueAw-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QueueAw:0]     count_ff;
   logic                 do_push, do_pop;

   assign full       = (count_ff == (QueueAw+1)'(QueueDepth));
   assign work_valid = (count_ff != '0);
   assign work       = queue_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = work_valid && work_ready;

   always_ff @(posedge clock) begin
      if (do_push) queue_ff[wr_ptr_ff] <= item;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (do_pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_ff + (QueueAw+1)'(do_push) - (QueueAw+1)'(do_pop);
      end
   end

endmodule

// ===== src/cbr_back.sv =====
module cbr_back
   import cbr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        work_valid,
   input  work_type    work,
   output logic        work_ready,
   output logic        empty,
   input  logic        pop,
   output logic [30:0] rsp_result_value,
   output logic [3:0]  rsp_result_filter,
   output logic [5:0]  rsp_result_row,
   output logic [5:0]  rsp_result_col,
   output logic        rsp_range_error
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_READ  = 5'b00010,
      ST_MAC   = 5'b00100,
      ST_BIAS  = 5'b01000,
      ST_SAT   = 5'b10000
   } state_type;

   logic signed [15:0] act_mem [ActDepth];
   logic signed [15:0] wgt_mem [WgtDepth];
   logic signed [31:0] bias_mem [MaxFilters];

   state_type state_ff, state_in;
   logic [3:0] ch_ff, ch_in;
   logic [2:0] kr_ff, kr_in, kc_ff, kc_in;
   work_type   job_ff;
   logic signed [15:0] act_rd_ff, wgt_rd_ff;
   logic signed [31:0] prod_ff, bias_rd_ff;
   logic signed [47:0] acc_ff, acc_in;
   logic       prod_v_ff, rd_v_ff;
   logic       out_valid_ff;
   logic [30:0] out_value_ff;
   logic [3:0]  out_filter_ff;
   logic [5:0]  out_row_ff, out_col_ff;
   logic        out_err_ff;

   logic take;
   logic sat_done;
   logic [ActAw-1:0] act_wa, act_ra;
   logic [WgtAw-1:0] wgt_wa, wgt_ra;
   logic [5:0] tap_row, tap_col;

   assign work_ready = (state_ff == ST_IDLE);
   assign take       = work_valid && work_ready;
   // the clamp step hands over only once the output register is free or being read
   assign sat_done   = (state_ff == ST_SAT) && (!out_valid_ff || pop);

   // Store writes happen straight from the queue head.
   assign act_wa = {work.channel, work.row, work.col};
   assign wgt_wa = WgtAw'(((((14'(work.filter) * 14'(MaxChannels)) + 14'(work.channel))
                          * 14'(MaxKernel) + 14'(work.krow)) * 14'(MaxKernel))
                          + 14'(work.kcol));

   always_ff @(posedge clock) begin
      if (take && work.cmd == CMD_WRITE_ACT)
         act_mem[act_wa] <= work.data;
      if (take && work.cmd == CMD_WRITE_WGT && work.krow < 3'(MaxKernel)
          && work.kcol < 3'(MaxKernel))
         wgt_mem[wgt_wa] <= work.data;
      if (take && work.cmd == CMD_WRITE_BIAS)
         bias_mem[work.filter] <= work.bias;
   end

   assign tap_row = job_ff.base_row + 6'(kr_ff);
   assign tap_col = job_ff.base_col + 6'(kc_ff);
   assign act_ra  = {ch_ff, tap_row, tap_col};
   assign wgt_ra  = WgtAw'(((((14'(job_ff.filter) * 14'(MaxChannels)) + 14'(ch_ff))
                           * 14'(MaxKernel) + 14'(kr_ff)) * 14'(MaxKernel))
                           + 14'(kc_ff));

   // Read port: one tap per cycle while in ST_READ.
   logic rd_issue;
   assign rd_issue = (state_ff == ST_READ);
   always_ff @(posedge clock) begin
      act_rd_ff  <= act_mem[act_ra];
      wgt_rd_ff  <= wgt_mem[wgt_ra];
      bias_rd_ff <= bias_mem[job_ff.filter];
      prod_ff    <= act_rd_ff * wgt_rd_ff;
   end

   always_comb begin
      state_in = state_ff;
      ch_in = ch_ff; kr_in = kr_ff; kc_in = kc_ff;
      acc_in = acc_ff;
      if (prod_v_ff) acc_in = acc_ff + 48'(prod_ff);
      unique case (state_ff)
         ST_IDLE: begin
            if (take && work.cmd == CMD_COMPUTE) begin
               ch_in = '0; kr_in = '0; kc_in = '0; acc_in = '0;
               state_in = work.range_error ? ST_SAT : ST_READ;
            end
         end
         ST_READ: begin
            if (kc_ff == cfg.win_size - 3'd1) begin
               kc_in = '0;
               if (kr_ff == cfg.win_size - 3'd1) begin
                  kr_in = '0;
                  if (5'(ch_ff) == cfg.in_depth - 5'd1) state_in = ST_MAC;
                  else ch_in = ch_ff + 4'd1;
               end else kr_in = kr_ff + 3'd1;
            end else kc_in = kc_ff + 3'd1;
         end
         ST_MAC: begin
            // drain read and product stages
            if (!rd_v_ff && !prod_v_ff) state_in = ST_BIAS;
         end
         ST_BIAS: begin
            acc_in   = acc_ff + 48'(bias_rd_ff);
            state_in = ST_SAT;
         end
         ST_SAT: state_in = sat_done ? ST_IDLE : ST_SAT;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_v_ff      <= 1'b0;
         prod_v_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_v_ff      <= rd_issue;
         prod_v_ff    <= rd_v_ff;
         if (sat_done) out_valid_ff <= 1'b1;
         else if (pop && out_valid_ff) out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      ch_ff <= ch_in; kr_ff <= kr_in; kc_ff <= kc_in;
      acc_ff <= acc_in;
      if (take) job_ff <= work;
      if (sat_done) begin
         if (job_ff.range_error || acc_ff <= 48'sd0) out_value_ff <= '0;
         else if (acc_ff > 48'sh7FFF_FFFF) out_value_ff <= 31'h7FFF_FFFF;
         else out_value_ff <= acc_ff[30:0];
         out_filter_ff <= job_ff.filter;
         out_row_ff    <= job_ff.row;
         out_col_ff    <= job_ff.col;
         out_err_ff    <= job_ff.range_error;
      end
   end

   assign empty             = !out_valid_ff;
   assign rsp_result_value  = out_value_ff;
   assign rsp_result_filter = out_filter_ff;
   assign rsp_result_row    = out_row_ff;
   assign rsp_result_col    = out_col_ff;
   assign rsp_range_error   = out_err_ff;

endmodule

// ===== src/conv2d_bias_relu_engine.sv =====
// channel  ports                            handshake
// request  req_*, push, full                taken when push && !full
// response rsp_*, empty, pop                taken when pop && !empty
// config   csr_write, csr_index, csr_data   taken when csr_write
// Writes go into the stores as the back end takes them. A compute holds the
// back end over in_depth*side^2 taps (one MAC per cycle), a drain of the read
// and product stages, the bias step and the clamp step; a range error goes
// straight to the clamp step. A four-entry queue lets requests gather while
// the back end works. Synchronous active-high reset; stores are not cleared.
// The result sits in an output register; the clamp step waits only while that
// register is still unread.
module conv2d_bias_relu_engine
   import cbr_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write,
   input  logic [2:0]         csr_index,
   input  logic [6:0]         csr_data,
   input  logic               push,
   output logic               full,
   input  logic [1:0]         req_command,
   input  logic [3:0]         req_filter_index,
   input  logic [3:0]         req_channel_index,
   input  logic [5:0]         req_row_index,
   input  logic [5:0]         req_col_index,
   input  logic [2:0]         req_kernel_row,
   input  logic [2:0]         req_kernel_col,
   input  logic signed [15:0] req_data_value,
   input  logic signed [31:0] req_bias_value,
   output logic               empty,
   input  logic               pop,
   output logic [30:0]        rsp_result_value,
   output logic [3:0]         rsp_result_filter,
   output logic [5:0]         rsp_result_row,
   output logic [5:0]         rsp_result_col,
   output logic               rsp_range_error
);

   cfg_type  cfg;
   work_type work;
   logic     work_valid, work_ready;

   cbr_front u_front (
      .clock, .reset, .csr_write, .csr_index, .csr_data, .push, .full,
      .req_command, .req_filter_index, .req_channel_index, .req_row_index,
      .req_col_index, .req_kernel_row, .req_kernel_col, .req_data_value,
      .req_bias_value, .cfg, .work_valid, .work, .work_ready
   );

   cbr_back u_back (
      .clock, .reset, .cfg, .work_valid, .work, .work_ready, .empty, .pop,
      .rsp_result_value, .rsp_result_filter, .rsp_result_row,
      .rsp_result_col, .rsp_range_error
   );

endmodule

// ===== src/cbr_checker.sv =====
module cbr_checker
   import cbr_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        full,
   input logic        empty,
   input logic        pop,
   input logic [30:0] rsp_result_value,
   input logic        rsp_range_error
);

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_range_error |-> rsp_result_value == '0)
      else $error("range error with nonzero value");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      !empty && !pop |=> !empty && $stable(rsp_result_value))
      else $error("result changed while waiting");

   a_reset_empty: assert property (@(posedge clock)
      !reset && $past(reset) |-> empty && !full)
      else $error("not empty after reset");

endmodule

bind conv2d_bias_relu_engine cbr_checker u_cbr_checker (
   .clock, .reset, .full, .empty, .pop, .rsp_result_value, .rsp_range_error
);
